>>> design/sigma_outlier_rejection_macros.svh
// Assertion macros shared by the sigma outlier rejection RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef SIGMA_OUTLIER_REJECTION_MACROS_SVH
`define SIGMA_OUTLIER_REJECTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SOR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sor: implication check failed");

// Next-cycle implication, disabled during reset.
`define SOR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sor: next-cycle check failed");

`endif

>>> design/sor_pkg.sv
// Shared types, constants and helpers for the sigma outlier rejection block.
// No dependencies; every other design file but the assertion macro header imports this package.
package sor_pkg;

  localparam int LANES = 8;
  localparam int COUNT_BITS = $clog2(LANES + 1);

  // Two deviations squared gives a factor of four on the variance side.
  localparam int SIGMA_FACTOR = 2;
  localparam int SIGMA_SQ_SHIFT = $clog2(SIGMA_FACTOR * SIGMA_FACTOR);

  // With n readings the largest normalized squared distance is n - 1, so
  // no reading can be rejected unless n - 1 exceeds the squared factor.
  localparam int MIN_REJECT_LANES = SIGMA_FACTOR * SIGMA_FACTOR + 2;

  typedef logic [LANES-1:0] lane_mask_t;
  typedef logic [COUNT_BITS-1:0] lane_count_t;

  function automatic lane_count_t count_lanes(input lane_mask_t m);
    lane_count_t c;
    c = '0;
    for (int i = 0; i < LANES; i++) begin
      c = c + lane_count_t'(m[i]);
    end
    return c;
  endfunction

endpackage

>>> design/sor_ifs.sv
// Valid/ready channel interfaces for the sensor word and the result word.
// Depends on sor_pkg for the lane mask and count types.
interface sor_in_if import sor_pkg::*; #(
  parameter int VALUE_BITS = 32
) ();
  logic valid;
  logic ready;
  logic signed [VALUE_BITS-1:0] value_0;
  logic signed [VALUE_BITS-1:0] value_1;
  logic signed [VALUE_BITS-1:0] value_2;
  logic signed [VALUE_BITS-1:0] value_3;
  logic signed [VALUE_BITS-1:0] value_4;
  logic signed [VALUE_BITS-1:0] value_5;
  logic signed [VALUE_BITS-1:0] value_6;
  logic signed [VALUE_BITS-1:0] value_7;
  lane_mask_t active_mask;

  modport source (
    output valid, value_0, value_1, value_2, value_3,
    output value_4, value_5, value_6, value_7, active_mask,
    input ready
  );
  modport sink (
    input valid, value_0, value_1, value_2, value_3,
    input value_4, value_5, value_6, value_7, active_mask,
    output ready
  );
endinterface

interface sor_out_if import sor_pkg::*; ();
  logic valid;
  logic ready;
  lane_mask_t kept_mask;
  lane_count_t kept_count;

  modport source (output valid, kept_mask, kept_count, input ready);
  modport sink (input valid, kept_mask, kept_count, output ready);
endinterface

>>> design/sor_stats.sv
// First two pipeline stages: valid count and sum, then per-lane |n*x - S|.
// Depends on sor_pkg.
module sor_stats import sor_pkg::*; #(
  parameter int VALUE_BITS = 32,
  localparam int SUM_W = VALUE_BITS + 3,
  localparam int NX_W = VALUE_BITS + 4,
  localparam int D_W = VALUE_BITS + 3
) (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  logic signed [VALUE_BITS-1:0] value [LANES],
  input  lane_mask_t active_mask,
  output logic dn_valid,
  input  logic dn_ready,
  output lane_mask_t mask,
  output lane_count_t n,
  output logic [D_W-1:0] dev [LANES]
);

  logic a_valid;
  logic a_adv;
  logic b_adv;
  logic signed [VALUE_BITS-1:0] a_value [LANES];
  lane_mask_t a_mask;
  lane_count_t a_n;
  logic signed [SUM_W-1:0] a_sum;

  logic signed [SUM_W-1:0] term [LANES];
  logic signed [SUM_W-1:0] pair [LANES/2];
  logic signed [SUM_W-1:0] quad [LANES/4];
  logic signed [SUM_W-1:0] sum_next;

  logic signed [NX_W-1:0] nx [LANES];
  logic signed [NX_W-1:0] t [LANES];
  logic [D_W-1:0] dev_next [LANES];

  assign a_adv = !a_valid || b_adv;
  assign b_adv = !dn_valid || dn_ready;
  assign up_ready = a_adv;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      term[i] = active_mask[i] ? SUM_W'(value[i]) : '0;
    end
    for (int k = 0; k < LANES/2; k++) begin
      pair[k] = term[2*k] + term[2*k+1];
    end
    for (int k = 0; k < LANES/4; k++) begin
      quad[k] = pair[2*k] + pair[2*k+1];
    end
    sum_next = quad[0] + quad[1];
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      nx[i] = NX_W'($signed({1'b0, a_n})) * NX_W'(a_value[i]);
      t[i] = nx[i] - NX_W'(a_sum);
      if (a_mask[i]) begin
        dev_next[i] = t[i][NX_W-1] ? D_W'(-t[i]) : D_W'(t[i]);
      end else begin
        dev_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid <= up_valid;
      end
      if (b_adv) begin
        dn_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && up_valid) begin
      a_value <= value;
      a_mask <= active_mask;
      a_n <= count_lanes(active_mask);
      a_sum <= sum_next;
    end
    if (b_adv && a_valid) begin
      mask <= a_mask;
      n <= a_n;
      dev <= dev_next;
    end
  end

endmodule

>>> design/sor_square.sv
// Stages three and four: square each deviation, then form n*d^2 per lane
// and four times the sum of squares. Depends on sor_pkg.
module sor_square import sor_pkg::*; #(
  parameter int VALUE_BITS = 32,
  localparam int D_W = VALUE_BITS + 3,
  localparam int SQ_W = 2 * D_W,
  localparam int SS_W = SQ_W + 3,
  localparam int F_W = SS_W + SIGMA_SQ_SHIFT,
  localparam int NSQ_W = SQ_W + COUNT_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  lane_mask_t up_mask,
  input  lane_count_t up_n,
  input  logic [D_W-1:0] dev [LANES],
  output logic dn_valid,
  input  logic dn_ready,
  output lane_mask_t mask,
  output lane_count_t n,
  output logic [F_W-1:0] bound,
  output logic [NSQ_W-1:0] nsq [LANES]
);

  logic c_valid;
  logic c_adv;
  logic d_adv;
  lane_mask_t c_mask;
  lane_count_t c_n;
  logic [SQ_W-1:0] c_sq [LANES];

  logic [SQ_W-1:0] sq_next [LANES];
  logic [SS_W-1:0] pair [LANES/2];
  logic [SS_W-1:0] quad [LANES/4];
  logic [SS_W-1:0] sumsq;
  logic [NSQ_W-1:0] nsq_next [LANES];

  assign c_adv = !c_valid || d_adv;
  assign d_adv = !dn_valid || dn_ready;
  assign up_ready = c_adv;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sq_next[i] = SQ_W'(dev[i]) * SQ_W'(dev[i]);
    end
  end

  always_comb begin
    for (int k = 0; k < LANES/2; k++) begin
      pair[k] = SS_W'(c_sq[2*k]) + SS_W'(c_sq[2*k+1]);
    end
    for (int k = 0; k < LANES/4; k++) begin
      quad[k] = pair[2*k] + pair[2*k+1];
    end
    sumsq = quad[0] + quad[1];
    for (int i = 0; i < LANES; i++) begin
      nsq_next[i] = NSQ_W'(c_n) * NSQ_W'(c_sq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (c_adv) begin
        c_valid <= up_valid;
      end
      if (d_adv) begin
        dn_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv && up_valid) begin
      c_mask <= up_mask;
      c_n <= up_n;
      c_sq <= sq_next;
    end
    if (d_adv && c_valid) begin
      mask <= c_mask;
      n <= c_n;
      bound <= F_W'(sumsq) << SIGMA_SQ_SHIFT;
      nsq <= nsq_next;
    end
  end

endmodule

>>> design/sor_decide.sv
// Final stage: compares each lane against the bound and registers the
// result word. Depends on sor_pkg and the assertion macro header.
`include "sigma_outlier_rejection_macros.svh"

module sor_decide import sor_pkg::*; #(
  parameter int VALUE_BITS = 32,
  localparam int SQ_W = 2 * (VALUE_BITS + 3),
  localparam int F_W = SQ_W + 3 + SIGMA_SQ_SHIFT,
  localparam int NSQ_W = SQ_W + COUNT_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  lane_mask_t up_mask,
  input  lane_count_t up_n,
  input  logic [F_W-1:0] bound,
  input  logic [NSQ_W-1:0] nsq [LANES],
  output logic out_valid,
  input  logic out_ready,
  output lane_mask_t kept_mask,
  output lane_count_t kept_count
);

  logic e_adv;
  lane_mask_t e_mask;
  lane_count_t e_n;
  lane_mask_t kept_next;

  assign e_adv = !out_valid || out_ready;
  assign up_ready = e_adv;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      kept_next[i] = up_mask[i] && (F_W'(nsq[i]) <= bound);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_adv) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv && up_valid) begin
      e_mask <= up_mask;
      e_n <= up_n;
      kept_mask <= kept_next;
      kept_count <= count_lanes(kept_next);
    end
  end

  `SOR_ASSERT_IMPLY(a_kept_subset, out_valid, (kept_mask & ~e_mask) == '0)
  `SOR_ASSERT_IMPLY(a_count_match, out_valid, kept_count == count_lanes(kept_mask))
  `SOR_ASSERT_IMPLY(a_few_lanes_kept, out_valid && (e_n < COUNT_BITS'(MIN_REJECT_LANES)), kept_mask == e_mask)
  `SOR_ASSERT_NEXT(a_word_lands, up_valid && up_ready, out_valid)

endmodule

>>> design/sigma_outlier_rejection.sv
// Top level of the two-sigma outlier rejection block.
// Depends on sor_pkg, sor_ifs, sor_stats, sor_square and sor_decide.
//
// Each input word carries eight signed readings and a mask of the valid
// ones; each output word gives the mask of readings within two population
// deviations of their mean and its bit count. The block takes one word
// per clock while the output is not stalled. Each word passes through
// count and sum, deviation |n*x - S|, squaring, scaling and summing,
// and the compare into the output register. The squaring stage, one
// multiplier of VALUE_BITS+3 bits per lane, sets the clock. Every stage
// holds its word under back-pressure and empty stages fill, so the input
// keeps accepting while a result waits at the output until every stage is full.
module sigma_outlier_rejection import sor_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input logic clk,
  input logic rst,
  sor_in_if.sink in_ch,
  sor_out_if.source out_ch
);

  localparam int D_W = VALUE_BITS + 3;
  localparam int SQ_W = 2 * D_W;
  localparam int F_W = SQ_W + 3 + SIGMA_SQ_SHIFT;
  localparam int NSQ_W = SQ_W + COUNT_BITS;

  logic signed [VALUE_BITS-1:0] value [LANES];

  logic st_valid;
  logic st_ready;
  lane_mask_t st_mask;
  lane_count_t st_n;
  logic [D_W-1:0] st_dev [LANES];

  logic sq_valid;
  logic sq_ready;
  lane_mask_t sq_mask;
  lane_count_t sq_n;
  logic [F_W-1:0] sq_bound;
  logic [NSQ_W-1:0] sq_nsq [LANES];

  assign value[0] = in_ch.value_0;
  assign value[1] = in_ch.value_1;
  assign value[2] = in_ch.value_2;
  assign value[3] = in_ch.value_3;
  assign value[4] = in_ch.value_4;
  assign value[5] = in_ch.value_5;
  assign value[6] = in_ch.value_6;
  assign value[7] = in_ch.value_7;

  sor_stats #(.VALUE_BITS(VALUE_BITS)) u_stats (
    .clk(clk),
    .rst(rst),
    .up_valid(in_ch.valid),
    .up_ready(in_ch.ready),
    .value(value),
    .active_mask(in_ch.active_mask),
    .dn_valid(st_valid),
    .dn_ready(st_ready),
    .mask(st_mask),
    .n(st_n),
    .dev(st_dev)
  );

  sor_square #(.VALUE_BITS(VALUE_BITS)) u_square (
    .clk(clk),
    .rst(rst),
    .up_valid(st_valid),
    .up_ready(st_ready),
    .up_mask(st_mask),
    .up_n(st_n),
    .dev(st_dev),
    .dn_valid(sq_valid),
    .dn_ready(sq_ready),
    .mask(sq_mask),
    .n(sq_n),
    .bound(sq_bound),
    .nsq(sq_nsq)
  );

  sor_decide #(.VALUE_BITS(VALUE_BITS)) u_decide (
    .clk(clk),
    .rst(rst),
    .up_valid(sq_valid),
    .up_ready(sq_ready),
    .up_mask(sq_mask),
    .up_n(sq_n),
    .bound(sq_bound),
    .nsq(sq_nsq),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .kept_mask(out_ch.kept_mask),
    .kept_count(out_ch.kept_count)
  );

endmodule

>>> test/sor_result_checker.sv
`timescale 1ns / 1ps
// Checker for sigma_outlier_rejection. It watches both channels, predicts the kept mask of
// every accepted sensor word and compares it with each accepted result word.
// Depends on sor_pkg and the channel interfaces in sor_ifs.
module sor_result_checker import sor_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input logic clk,
  input logic rst,
  sor_in_if in_ch,
  sor_out_if out_ch,
  output int mismatches,
  output int pending_words
);

  typedef logic [LANES-1:0][VALUE_BITS-1:0] readings_t;

  typedef struct packed {
    lane_mask_t kept_mask;
    lane_count_t kept_count;
  } kept_result_t;

  kept_result_t expected_kept_q [$];

  // The exact two-sigma test (n*x - S)^2 > 4*(n*Q - S^2), written as n*d^2 > 4*sum(d^2).
  function automatic kept_result_t clip_two_sigma(input readings_t rd, input lane_mask_t act);
    longint n;
    longint total;
    longint dev;
    logic [127:0] dev_sq [LANES];
    logic [127:0] bound;
    kept_result_t res;
    n = 0;
    total = 0;
    bound = '0;
    res.kept_mask = act;
    for (int i = 0; i < LANES; i++) begin
      if (act[i]) begin
        n++;
        total += longint'(signed'(rd[i]));
      end
    end
    for (int i = 0; i < LANES; i++) begin
      dev_sq[i] = '0;
      if (act[i]) begin
        dev = n * longint'(signed'(rd[i])) - total;
        if (dev < 0) begin
          dev = -dev;
        end
        dev_sq[i] = 128'(dev) * 128'(dev);
        bound += dev_sq[i];
      end
    end
    bound = bound << 2;
    for (int i = 0; i < LANES; i++) begin
      if (act[i] && (128'(n) * dev_sq[i] > bound)) begin
        res.kept_mask[i] = 1'b0;
      end
    end
    res.kept_count = lane_count_t'($countones(res.kept_mask));
    return res;
  endfunction

  always @(posedge clk) begin : watch
    kept_result_t want;
    readings_t rd;
    int errs;
    errs = 0;
    if (rst) begin
      expected_kept_q.delete();
      mismatches <= 0;
      pending_words <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rd = {in_ch.value_7, in_ch.value_6, in_ch.value_5, in_ch.value_4,
              in_ch.value_3, in_ch.value_2, in_ch.value_1, in_ch.value_0};
        expected_kept_q.push_back(clip_two_sigma(rd, in_ch.active_mask));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_kept_q.size() == 0) begin
          $display("%0t: result word with none expected: kept_mask %h kept_count %0d",
                   $time, out_ch.kept_mask, out_ch.kept_count);
          errs++;
        end else begin
          want = expected_kept_q.pop_front();
          if (out_ch.kept_mask !== want.kept_mask) begin
            $display("%0t: kept_mask mismatch: expected %h actual %h",
                     $time, want.kept_mask, out_ch.kept_mask);
            errs++;
          end
          if (out_ch.kept_count !== want.kept_count) begin
            $display("%0t: kept_count mismatch: expected %0d actual %0d",
                     $time, want.kept_count, out_ch.kept_count);
            errs++;
          end
        end
      end
      mismatches <= mismatches + errs;
      pending_words <= expected_kept_q.size();
    end
  end

endmodule

>>> test/tb_sigma_outlier_rejection.sv
`timescale 1ns / 1ps
// Testbench top for sigma_outlier_rejection: drives directed and random sensor words with
// random gaps and output stalls; sor_result_checker predicts and compares the results.
// Depends on sor_pkg, sor_ifs, sor_result_checker and the block itself.
module tb_sigma_outlier_rejection import sor_pkg::*;;

  localparam int VALUE_BITS = 32;
  localparam int NUM_RANDOM = 580;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [VALUE_BITS-1:0] MAX_READING = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] MIN_READING = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef logic [LANES-1:0][VALUE_BITS-1:0] readings_t;

  logic clk;
  logic rst;
  bit idle_on;
  int quiet_cycles;
  int mismatches;
  int pending_words;

  sor_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  sor_out_if out_ch ();

  sigma_outlier_rejection #(.VALUE_BITS(VALUE_BITS)) i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  sor_result_checker #(.VALUE_BITS(VALUE_BITS)) i_checker (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .mismatches(mismatches),
    .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic readings_t fill(input logic [VALUE_BITS-1:0] v);
    readings_t rd;
    for (int i = 0; i < LANES; i++) begin
      rd[i] = v;
    end
    return rd;
  endfunction

  task automatic send_word(input readings_t rd, input lane_mask_t act);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.value_0 <= rd[0];
    in_ch.value_1 <= rd[1];
    in_ch.value_2 <= rd[2];
    in_ch.value_3 <= rd[3];
    in_ch.value_4 <= rd[4];
    in_ch.value_5 <= rd[5];
    in_ch.value_6 <= rd[6];
    in_ch.value_7 <= rd[7];
    in_ch.active_mask <= act;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Most words are a tight cluster with a few far readings, so rejection is exercised often.
  task automatic send_random();
    readings_t rd;
    lane_mask_t act;
    int kind;
    int spread;
    int far_count;
    logic [VALUE_BITS-1:0] center;
    logic [VALUE_BITS-1:0] offset;
    kind = $urandom_range(0, 99);
    act = ($urandom_range(0, 3) == 0) ? lane_mask_t'($urandom) : '1;
    if (kind < 60) begin
      center = $urandom;
      spread = $urandom_range(0, 16);
      for (int i = 0; i < LANES; i++) begin
        rd[i] = center + ($urandom & ((32'd1 << spread) - 1));
      end
      far_count = $urandom_range(0, 2);
      for (int k = 0; k < far_count; k++) begin
        offset = 32'd1 << $urandom_range(spread + 2, 30);
        if ($urandom_range(0, 1) == 1) begin
          offset = -offset;
        end
        rd[$urandom_range(0, LANES - 1)] = center + offset;
      end
    end else if (kind < 85) begin
      for (int i = 0; i < LANES; i++) begin
        rd[i] = $urandom;
      end
    end else begin
      for (int i = 0; i < LANES; i++) begin
        case ($urandom_range(0, 4))
          0: rd[i] = MIN_READING;
          1: rd[i] = MAX_READING;
          2: rd[i] = '0;
          3: rd[i] = '1;
          default: rd[i] = 1;
        endcase
      end
    end
    send_word(rd, act);
  endtask

  // Output side: stall a random number of cycles before taking each result word.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    readings_t rd;
    rst <= 1'b1;
    idle_on = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.value_0 <= '0;
    in_ch.value_1 <= '0;
    in_ch.value_2 <= '0;
    in_ch.value_3 <= '0;
    in_ch.value_4 <= '0;
    in_ch.value_5 <= '0;
    in_ch.value_6 <= '0;
    in_ch.value_7 <= '0;
    in_ch.active_mask <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(fill($urandom), '0);
    send_word(fill(32'd7), 8'h10);
    rd = fill(32'd12345);
    rd[2] = MIN_READING;
    send_word(rd, 8'h08);
    send_word(fill(32'd12345), '1);
    send_word(fill(MAX_READING), '1);
    send_word(fill(MIN_READING), '1);
    rd = fill('0);
    rd[3] = 32'd1000;
    send_word(rd, '1);
    rd = fill(MIN_READING);
    rd[7] = MAX_READING;
    send_word(rd, '1);
    rd = fill(MAX_READING);
    rd[0] = MIN_READING;
    send_word(rd, '1);
    // With five readings a single far one sits exactly on the limit and is kept.
    rd = fill('0);
    rd[0] = 32'd100;
    send_word(rd, 8'h1F);
    send_word(rd, 8'h3F);
    rd = fill('0);
    rd[5] = MAX_READING;
    send_word(rd, 8'hDF);
    rd = fill('0);
    rd[1] = 32'd1000;
    rd[6] = -32'sd1000;
    send_word(rd, '1);
    for (int i = 0; i < LANES; i++) begin
      rd[i] = i[0] ? MAX_READING : MIN_READING;
    end
    send_word(rd, '1);
    for (int i = 0; i < LANES; i++) begin
      rd[i] = i;
    end
    rd[4] = 32'd1000000;
    send_word(rd, '1);
    rd = fill('1);
    rd[6] = MIN_READING;
    send_word(rd, 8'hC3);
    send_word(fill('1), '1);

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k % 40 == 0) begin
        idle_on = $urandom_range(0, 3) != 0;
      end
      send_random();
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_words == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sigma_outlier_rejection.f
+incdir+design
design/sor_pkg.sv
design/sor_ifs.sv
design/sor_stats.sv
design/sor_square.sv
design/sor_decide.sv
design/sigma_outlier_rejection.sv
test/sor_result_checker.sv
test/tb_sigma_outlier_rejection.sv
